/* sv/multidim_histogram_binner_unit_macros.svh */
// ---------------------------------------------------------------------------
// Histogram binner assertion macros
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef MULTIDIM_HISTOGRAM_BINNER_UNIT_MACROS_SVH
`define MULTIDIM_HISTOGRAM_BINNER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define MHB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram binner assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define MHB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram binner assertion failed");
`else
`define MHB_ASSERT_NOW(label, ante, cons)
`define MHB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/mhb_pkg.sv */
// ---------------------------------------------------------------------------
// Histogram binner package
// Shared types, codes and constants of the histogram binner.
// ---------------------------------------------------------------------------
package mhb_pkg;

  localparam int IDX_W     = 12;
  localparam int OUT_CNT_W = 16;
  localparam int SAMPLE_W  = 16;
  localparam int SCALE_W   = 24;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  localparam int DEF_BINS_X      = 16;
  localparam int DEF_BINS_Y      = 16;
  localparam int DEF_BINS_Z      = 16;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h010000;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_LOWER_X = 3'd0,
    REG_LOWER_Y = 3'd1,
    REG_LOWER_Z = 3'd2,
    REG_SCALE_X = 3'd3,
    REG_SCALE_Y = 3'd4,
    REG_SCALE_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_BIN,
    ST_LIN,
    ST_ADDR,
    ST_RD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lower_x;
    logic signed [SAMPLE_W-1:0] lower_y;
    logic signed [SAMPLE_W-1:0] lower_z;
    logic [SCALE_W-1:0]         scale_x;
    logic [SCALE_W-1:0]         scale_y;
    logic [SCALE_W-1:0]         scale_z;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic bin;
    logic lin;
    logic addr;
    logic mem_rd;
    logic mem_we;
    logic done;
    logic clr_start;
    logic clr_run;
    cmd_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/mhb_ifs.sv */
// ---------------------------------------------------------------------------
// Histogram binner channel interfaces
// Valid/ready channels for sample commands and for results.
// ---------------------------------------------------------------------------
interface mhb_in_if;
  import mhb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic signed [SAMPLE_W-1:0] sample_z;
  logic [IDX_W-1:0]           read_index;

  modport source (output valid, command, sample_x, sample_y, sample_z, read_index,
                  input ready);
  modport sink (input valid, command, sample_x, sample_y, sample_z, read_index,
                output ready);
endinterface

interface mhb_out_if;
  import mhb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     bin_index;
  logic [OUT_CNT_W-1:0] bin_count;

  modport source (output valid, bin_index, bin_count, input ready);
  modport sink (input valid, bin_index, bin_count, output ready);
endinterface

/* sv/mhb_cfg.sv */
// ---------------------------------------------------------------------------
// Histogram binner configuration registers
// APB-style register file holding axis lower bounds and scales.
// ---------------------------------------------------------------------------
module mhb_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mhb_pkg::CFG_AW-1:0]  paddr,
  input  logic [mhb_pkg::CFG_DW-1:0]  pwdata,
  output logic [mhb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output mhb_pkg::cfg_t               cfg
);
  import mhb_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_e'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_LOWER_X: cfg_nxt.lower_x = pwdata[SAMPLE_W-1:0];
        REG_LOWER_Y: cfg_nxt.lower_y = pwdata[SAMPLE_W-1:0];
        REG_LOWER_Z: cfg_nxt.lower_z = pwdata[SAMPLE_W-1:0];
        REG_SCALE_X: cfg_nxt.scale_x = pwdata[SCALE_W-1:0];
        REG_SCALE_Y: cfg_nxt.scale_y = pwdata[SCALE_W-1:0];
        REG_SCALE_Z: cfg_nxt.scale_z = pwdata[SCALE_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LOWER_X: prdata = CFG_DW'(cfg_r.lower_x);
      REG_LOWER_Y: prdata = CFG_DW'(cfg_r.lower_y);
      REG_LOWER_Z: prdata = CFG_DW'(cfg_r.lower_z);
      REG_SCALE_X: prdata = CFG_DW'(cfg_r.scale_x);
      REG_SCALE_Y: prdata = CFG_DW'(cfg_r.scale_y);
      REG_SCALE_Z: prdata = CFG_DW'(cfg_r.scale_z);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lower_x <= '0;
      cfg_r.lower_y <= '0;
      cfg_r.lower_z <= '0;
      cfg_r.scale_x <= SCALE_RESET;
      cfg_r.scale_y <= SCALE_RESET;
      cfg_r.scale_z <= SCALE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/mhb_ctrl.sv */
// ---------------------------------------------------------------------------
// Histogram binner controller
// Sequences clearing passes, bin computation, counter updates and reads.
// ---------------------------------------------------------------------------
module mhb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  mhb_pkg::cmd_e        in_cmd,
  output logic                 in_ready,
  input  mhb_pkg::dp_stat_t    stat,
  output mhb_pkg::ctrl_cmd_t   cmd
);
  import mhb_pkg::*;

  state_e state_r;
  state_e state_nxt;
  cmd_e   op_r;
  cmd_e   op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      op_r    <= CMD_NOP;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.op    = op_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_run = 1'b1;
        cmd.mem_we  = 1'b1;
        if (stat.clr_last) begin
          // A clear command still owes its result; the pass after reset does not.
          state_nxt = (op_r == CMD_CLEAR) ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          op_nxt      = in_cmd;
          unique case (in_cmd)
            CMD_ADD:   state_nxt = ST_MUL;
            CMD_READ:  state_nxt = ST_ADDR;
            CMD_CLEAR: begin
              state_nxt     = ST_CLEAR;
              cmd.clr_start = 1'b1;
            end
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_BIN;
      end
      ST_BIN: begin
        cmd.bin   = 1'b1;
        state_nxt = ST_LIN;
      end
      ST_LIN: begin
        cmd.lin   = 1'b1;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.done   = 1'b1;
          cmd.mem_we = (op_r == CMD_ADD);
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* sv/mhb_dp.sv */
// ---------------------------------------------------------------------------
// Histogram binner datapath
// Axis binning arithmetic, counter memory and the result register.
// ---------------------------------------------------------------------------
module mhb_dp #(
  parameter int BINS_X      = mhb_pkg::DEF_BINS_X,
  parameter int BINS_Y      = mhb_pkg::DEF_BINS_Y,
  parameter int BINS_Z      = mhb_pkg::DEF_BINS_Z,
  parameter int COUNT_WIDTH = mhb_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mhb_pkg::cfg_t                        cfg,
  input  mhb_pkg::ctrl_cmd_t                   cmd,
  output mhb_pkg::dp_stat_t                    stat,
  input  logic signed [mhb_pkg::SAMPLE_W-1:0]  in_sample_x,
  input  logic signed [mhb_pkg::SAMPLE_W-1:0]  in_sample_y,
  input  logic signed [mhb_pkg::SAMPLE_W-1:0]  in_sample_z,
  input  logic [mhb_pkg::IDX_W-1:0]            in_read_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mhb_pkg::IDX_W-1:0]            out_bin_index,
  output logic [mhb_pkg::OUT_CNT_W-1:0]        out_bin_count
);
  import mhb_pkg::*;

  localparam int DEPTH  = 1 << IDX_W;
  localparam int BXW    = (BINS_X > 1) ? $clog2(BINS_X) : 1;
  localparam int BYW    = (BINS_Y > 1) ? $clog2(BINS_Y) : 1;
  localparam int BZW    = (BINS_Z > 1) ? $clog2(BINS_Z) : 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + SCALE_W + 1;
  localparam int Q_W    = PROD_W - 1 - 16;

  localparam logic [Q_W-1:0] LIM_X = Q_W'(BINS_X - 1);
  localparam logic [Q_W-1:0] LIM_Y = Q_W'(BINS_Y - 1);
  localparam logic [Q_W-1:0] LIM_Z = Q_W'(BINS_Z - 1);

  // Floor of the signed Q25.16 product, clamped to the axis range.
  function automatic logic [Q_W-1:0] clamp_bin(logic signed [PROD_W-1:0] p,
                                               logic [Q_W-1:0] lim);
    logic [Q_W-1:0] q;
    q = p[PROD_W-2:16];
    if (p <= 0) begin
      return '0;
    end else if (q > lim) begin
      return lim;
    end
    return q;
  endfunction

  logic [COUNT_WIDTH-1:0] mem [DEPTH];

  logic signed [SAMPLE_W-1:0] sx_r, sy_r, sz_r;
  logic [IDX_W-1:0]           ridx_r;
  logic signed [PROD_W-1:0]   px_r, py_r, pz_r;
  logic signed [PROD_W-1:0]   px_nxt, py_nxt, pz_nxt;
  logic [BXW-1:0]             bx_r;
  logic [BYW-1:0]             by_r;
  logic [BZW-1:0]             bz_r;
  logic [IDX_W-1:0]           row_r, row_nxt;
  logic [IDX_W-1:0]           addr_r, addr_nxt;
  logic [COUNT_WIDTH-1:0]     rdata_r;
  logic [COUNT_WIDTH-1:0]     inc_cnt;
  logic [COUNT_WIDTH-1:0]     sel_cnt;
  logic [OUT_CNT_W-1:0]       cnt_out;
  logic [IDX_W-1:0]           idx_out;
  logic [IDX_W-1:0]           clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0]           waddr;
  logic [COUNT_WIDTH-1:0]     wdata;
  logic                       out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]           out_idx_r;
  logic [OUT_CNT_W-1:0]       out_cnt_r;

  // Operands are sign-extended so the difference never overflows.
  assign px_nxt = ($signed({sx_r[SAMPLE_W-1], sx_r}) - $signed({cfg.lower_x[SAMPLE_W-1],
                  cfg.lower_x})) * $signed({1'b0, cfg.scale_x});
  assign py_nxt = ($signed({sy_r[SAMPLE_W-1], sy_r}) - $signed({cfg.lower_y[SAMPLE_W-1],
                  cfg.lower_y})) * $signed({1'b0, cfg.scale_y});
  assign pz_nxt = ($signed({sz_r[SAMPLE_W-1], sz_r}) - $signed({cfg.lower_z[SAMPLE_W-1],
                  cfg.lower_z})) * $signed({1'b0, cfg.scale_z});

  // Row-major index is kept modulo the store depth at each step.
  assign row_nxt  = IDX_W'(int'(bx_r) * BINS_Y + int'(by_r));
  assign addr_nxt = (cmd.op == CMD_ADD) ? IDX_W'(int'(row_r) * BINS_Z + int'(bz_r))
                                        : ridx_r;

  assign inc_cnt = (&rdata_r) ? rdata_r : rdata_r + COUNT_WIDTH'(1);

  always_comb begin
    case (cmd.op)
      CMD_ADD: begin
        sel_cnt = inc_cnt;
        idx_out = addr_r;
      end
      CMD_READ: begin
        sel_cnt = rdata_r;
        idx_out = addr_r;
      end
      default: begin
        sel_cnt = '0;
        idx_out = '0;
      end
    endcase
  end

  generate
    if (COUNT_WIDTH > OUT_CNT_W) begin : g_wide_cnt
      assign cnt_out = (|sel_cnt[COUNT_WIDTH-1:OUT_CNT_W]) ? '1 : sel_cnt[OUT_CNT_W-1:0];
    end else begin : g_narrow_cnt
      assign cnt_out = OUT_CNT_W'(sel_cnt);
    end
  endgenerate

  assign clr_addr_nxt = cmd.clr_start ? '0 :
                        cmd.clr_run   ? clr_addr_r + IDX_W'(1) : clr_addr_r;
  assign waddr = cmd.clr_run ? clr_addr_r : addr_r;
  assign wdata = cmd.clr_run ? '0 : inc_cnt;

  assign out_valid_nxt = cmd.done ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  assign stat.clr_last = &clr_addr_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_bin_index = out_idx_r;
  assign out_bin_count = out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx_r   <= in_sample_x;
      sy_r   <= in_sample_y;
      sz_r   <= in_sample_z;
      ridx_r <= in_read_index;
    end
    if (cmd.mul) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
    end
    if (cmd.bin) begin
      bx_r <= BXW'(clamp_bin(px_r, LIM_X));
      by_r <= BYW'(clamp_bin(py_r, LIM_Y));
      bz_r <= BZW'(clamp_bin(pz_r, LIM_Z));
    end
    if (cmd.lin) begin
      row_r <= row_nxt;
    end
    if (cmd.addr) begin
      addr_r <= addr_nxt;
    end
    if (cmd.done) begin
      out_idx_r <= idx_out;
      out_cnt_r <= cnt_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* sv/multidim_histogram_binner_unit.sv */
// ---------------------------------------------------------------------------
// Three-dimensional histogram binner
// Bins sample points into a 4096-entry store of saturating counters.
// ---------------------------------------------------------------------------
// One command is in flight at a time; a new one is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// An add steps through product, clamp, two index steps, counter read and
// write-back before the next command is accepted, a read through the address
// step, counter read and result, an unused command code straight to the result,
// and a clear through a clearing pass that writes one counter per cycle
// through the single write port. After reset the same clearing pass runs
// before the first command is accepted; register writes are taken at any time.
module multidim_histogram_binner_unit #(
  parameter int BINS_X      = mhb_pkg::DEF_BINS_X,
  parameter int BINS_Y      = mhb_pkg::DEF_BINS_Y,
  parameter int BINS_Z      = mhb_pkg::DEF_BINS_Z,
  parameter int COUNT_WIDTH = mhb_pkg::DEF_COUNT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mhb_in_if.sink                      in_ch,
  mhb_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mhb_pkg::CFG_AW-1:0]  paddr,
  input  logic [mhb_pkg::CFG_DW-1:0]  pwdata,
  output logic [mhb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import mhb_pkg::*;

`include "multidim_histogram_binner_unit_macros.svh"

  cfg_t       cfg;
  ctrl_cmd_t  ctrl_cmd;
  dp_stat_t   dp_stat;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  mhb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mhb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (cmd_e'(in_ch.command)),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  mhb_dp #(
    .BINS_X      (BINS_X),
    .BINS_Y      (BINS_Y),
    .BINS_Z      (BINS_Z),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (ctrl_cmd),
    .stat          (dp_stat),
    .in_sample_x   (in_ch.sample_x),
    .in_sample_y   (in_ch.sample_y),
    .in_sample_z   (in_ch.sample_z),
    .in_read_index (in_ch.read_index),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_bin_index (out_ch.bin_index),
    .out_bin_count (out_ch.bin_count)
  );

  // No transaction may enter while the counter store is being cleared.
  `MHB_ASSERT_NOW(a_no_accept_in_clear, ctrl_cmd.clr_run, !in_ch.ready)
  // An accepted clear command starts the clearing pass on the next cycle.
  `MHB_ASSERT_NEXT(a_clear_starts,
                   in_ch.valid && in_ch.ready && in_ch.command == CMD_CLEAR, ctrl_cmd.clr_run)
  // A result is loaded only when the output register is free.
  `MHB_ASSERT_NOW(a_load_when_free, ctrl_cmd.done, !out_ch.valid || out_ch.ready)
  // The counter store is never written while a command is being accepted.
  `MHB_ASSERT_NOW(a_no_write_on_accept, in_ch.valid && in_ch.ready, !ctrl_cmd.mem_we)

endmodule

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// Histogram binner testbench
// Streams add, read, clear and unused commands into the binner under several
// axis settings, predicts every result from a private copy of the counter
// store, and compares each result transaction field by field.
// ---------------------------------------------------------------------------
import mhb_pkg::*;

typedef struct packed {
  logic [IDX_W-1:0]     bin_index;
  logic [OUT_CNT_W-1:0] bin_count;
} bin_result_t;

class histogram_tracker;
  logic signed [SAMPLE_W-1:0] lower [3];
  logic [SCALE_W-1:0]         scale [3];
  logic [31:0]                counts [4096];
  bin_result_t                expected_q [$];
  int                         error_count;

  function new();
    foreach (lower[i]) lower[i] = '0;
    foreach (scale[i]) scale[i] = SCALE_RESET;
    foreach (counts[i]) counts[i] = '0;
    error_count = 0;
  endfunction

  function void set_register(cfg_reg_e sel, logic [CFG_DW-1:0] value);
    case (sel)
      REG_LOWER_X: lower[0] = value[SAMPLE_W-1:0];
      REG_LOWER_Y: lower[1] = value[SAMPLE_W-1:0];
      REG_LOWER_Z: lower[2] = value[SAMPLE_W-1:0];
      REG_SCALE_X: scale[0] = value[SCALE_W-1:0];
      REG_SCALE_Y: scale[1] = value[SCALE_W-1:0];
      REG_SCALE_Z: scale[2] = value[SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  // Floor of the offset times the Q8.16 scale, clamped to the axis bins.
  function int axis_bin(logic signed [SAMPLE_W-1:0] coord, int axis, int bin_limit);
    longint diff;
    longint prod;
    diff = longint'(coord) - longint'(lower[axis]);
    if (diff <= 0 || scale[axis] == '0) return 0;
    prod = (diff * longint'(scale[axis])) >>> 16;
    if (prod > bin_limit - 1) prod = bin_limit - 1;
    return int'(prod);
  endfunction

  function bin_result_t note_input(cmd_e cmd, logic signed [SAMPLE_W-1:0] cx,
                                   logic signed [SAMPLE_W-1:0] cy,
                                   logic signed [SAMPLE_W-1:0] cz,
                                   logic [IDX_W-1:0] ridx);
    bin_result_t res;
    int bx, by, bz;
    logic [IDX_W-1:0] lin;
    logic [31:0] top;
    top = 32'((64'd1 << DEF_COUNT_WIDTH) - 1);
    res = '0;
    case (cmd)
      CMD_ADD: begin
        bx = axis_bin(cx, 0, DEF_BINS_X);
        by = axis_bin(cy, 1, DEF_BINS_Y);
        bz = axis_bin(cz, 2, DEF_BINS_Z);
        lin = IDX_W'((bx * DEF_BINS_Y + by) * DEF_BINS_Z + bz);
        if (counts[lin] < top) counts[lin] = counts[lin] + 1;
        res.bin_index = lin;
        res.bin_count = (counts[lin] > 32'hFFFF) ? 16'hFFFF : counts[lin][15:0];
      end
      CMD_READ: begin
        res.bin_index = ridx;
        res.bin_count = (counts[ridx] > 32'hFFFF) ? 16'hFFFF : counts[ridx][15:0];
      end
      CMD_CLEAR: begin
        foreach (counts[i]) counts[i] = '0;
      end
      default: ;
    endcase
    expected_q.push_back(res);
    return res;
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction

  task report(string msg);
    error_count++;
    if (error_count <= 25) $display("mismatch: %s", msg);
  endtask

  task check_result(logic [IDX_W-1:0] got_index, logic [OUT_CNT_W-1:0] got_count);
    bin_result_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result index %0d count %0d", got_index, got_count));
    end else begin
      want = expected_q.pop_front();
      if (got_index !== want.bin_index)
        report($sformatf("bin_index %0d, expected %0d", got_index, want.bin_index));
      if (got_count !== want.bin_count)
        report($sformatf("bin_count %0d at index %0d, expected %0d",
                         got_count, want.bin_index, want.bin_count));
    end
  endtask
endclass

module testbench;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 300;
  localparam int NUM_PHASES  = 6;
  localparam int REPEAT_ADDS = 40;
  localparam logic signed [SAMPLE_W-1:0] COORD_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] COORD_MAX = 16'sh7FFF;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;

  mhb_in_if  in_ch ();
  mhb_out_if out_ch ();

  multidim_histogram_binner_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  histogram_tracker sb;

  logic signed [SAMPLE_W-1:0] axis_lo [3];
  logic [SCALE_W-1:0]         axis_scale [3];
  int                         axis_span [3];
  logic [IDX_W-1:0]           recent_bins [$];

  int          rx_mode = 0;
  int          rx_tick = 0;
  logic [15:0] rx_pattern = 16'hFFFF;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: always ready in mode 0, otherwise stepping through a random
  // 16-bit stall pattern whose first bit is always ready; mode 2 stalls more.
  always @(negedge clk) begin
    if (rx_tick == 0) begin
      rx_pattern = 16'($urandom) | 16'h1;
      if (rx_mode == 2) rx_pattern = (rx_pattern & 16'($urandom)) | 16'h1;
    end
    out_ch.ready <= (rx_mode == 0) ? 1'b1 : rx_pattern[rx_tick];
    rx_tick = (rx_tick + 1) % 16;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.bin_index, out_ch.bin_count);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (psel === 1'b1 && penable === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge with psel and
  // penable still high so that back-to-back writes stay glitch free.
  task automatic write_register(cfg_reg_e sel, logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_register(sel, value);
    @(negedge clk);
  endtask

  task automatic apply_axes();
    write_register(REG_LOWER_X, {16'h0000, axis_lo[0]});
    write_register(REG_LOWER_Y, {16'h0000, axis_lo[1]});
    write_register(REG_LOWER_Z, {16'h0000, axis_lo[2]});
    write_register(REG_SCALE_X, {8'h00, axis_scale[0]});
    write_register(REG_SCALE_Y, {8'h00, axis_scale[1]});
    write_register(REG_SCALE_Z, {8'h00, axis_scale[2]});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly a sensible range per axis, with zero, full and random scales mixed in.
  task automatic choose_axes();
    int kind;
    for (int a = 0; a < 3; a++) begin
      kind = $urandom_range(0, 9);
      axis_span[a] = $urandom_range(16, 65535);
      axis_lo[a] = 16'(int'($urandom_range(0, 65535 - axis_span[a])) - 32768);
      case (kind)
        0: axis_scale[a] = '0;
        1: axis_scale[a] = 24'hFFFFFF;
        2: axis_scale[a] = 24'($urandom);
        default: axis_scale[a] = 24'((DEF_BINS_X << 16) / axis_span[a]);
      endcase
    end
  endtask

  // Called at a falling edge; leaves valid high for a possible next transaction.
  task automatic send_item(cmd_e cmd, logic signed [SAMPLE_W-1:0] cx,
                           logic signed [SAMPLE_W-1:0] cy,
                           logic signed [SAMPLE_W-1:0] cz, logic [IDX_W-1:0] ridx);
    bin_result_t predicted;
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.sample_x   <= cx;
    in_ch.sample_y   <= cy;
    in_ch.sample_z   <= cz;
    in_ch.read_index <= ridx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = sb.note_input(cmd, cx, cy, cz, ridx);
    if (cmd == CMD_ADD) begin
      recent_bins.push_back(predicted.bin_index);
      if (recent_bins.size() > 32) void'(recent_bins.pop_front());
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_coord(int axis);
    int v;
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    v = int'(axis_lo[axis]) + int'($urandom_range(0, axis_span[axis] + axis_span[axis] / 4))
        - axis_span[axis] / 8;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  task automatic random_item();
    int pick;
    cmd_e cmd;
    logic [IDX_W-1:0] ridx;
    pick = $urandom_range(0, 999);
    if (pick < 690) cmd = CMD_ADD;
    else if (pick < 950) cmd = CMD_READ;
    else if (pick < 960) cmd = CMD_CLEAR;
    else cmd = CMD_NOP;
    if (recent_bins.size() > 0 && $urandom_range(0, 9) < 7)
      ridx = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
    else
      ridx = IDX_W'($urandom);
    send_item(cmd, pick_coord(0), pick_coord(1), pick_coord(2), ridx);
  endtask

  initial begin
    int n;
    int burst_left;
    int gap;
    bit gaps_on;
    sb = new();
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    in_ch.sample_z = '0;
    in_ch.read_index = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    rx_mode = 1;

    // Reset settings: unit scale, so each coordinate is its own bin, clamped.
    send_item(CMD_ADD, 16'sd0, 16'sd0, 16'sd0, 12'hFFF);
    send_item(CMD_ADD, COORD_MIN, -16'sd1, COORD_MAX, 12'h000);
    send_item(CMD_ADD, COORD_MAX, COORD_MAX, COORD_MAX, 12'h000);
    send_item(CMD_ADD, 16'sd5, 16'sd9, 16'sd3, 12'h000);
    send_item(CMD_ADD, 16'sd5, 16'sd9, 16'sd3, 12'h000);
    send_item(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 12'd0);
    send_item(CMD_READ, COORD_MIN, COORD_MIN, COORD_MIN, 12'hFFF);
    send_item(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 12'd1383);
    send_item(CMD_NOP, -16'sd1, -16'sd1, -16'sd1, 12'hFFF);
    send_item(CMD_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX, 12'hFFF);
    send_item(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 12'hFFF);
    send_item(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 12'd15);

    // Extreme settings: full scale on x, zero scale on y, a tiny scale on z.
    wait_drained();
    repeat (8) @(negedge clk);
    axis_lo[0] = COORD_MIN;  axis_scale[0] = 24'hFFFFFF; axis_span[0] = 65535;
    axis_lo[1] = COORD_MAX;  axis_scale[1] = '0;         axis_span[1] = 1;
    axis_lo[2] = COORD_MIN;  axis_scale[2] = 24'h000100; axis_span[2] = 65535;
    apply_axes();
    send_item(CMD_ADD, COORD_MIN, COORD_MAX, COORD_MIN, 12'h000);
    send_item(CMD_ADD, -16'sd32767, COORD_MIN, COORD_MAX, 12'h000);
    send_item(CMD_ADD, COORD_MAX, 16'sd0, -16'sd28928, 12'h000);
    send_item(CMD_ADD, 16'sd0, COORD_MAX, -16'sd28929, 12'h000);
    send_item(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 12'd3855);

    // Hammer one counter with back-to-back adds and no idling on either side.
    rx_mode = 0;
    for (int i = 0; i < REPEAT_ADDS; i++)
      send_item(CMD_ADD, COORD_MIN, COORD_MAX, COORD_MIN, 12'h000);
    send_item(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 12'd0);
    send_item(CMD_CLEAR, 16'sd0, 16'sd0, 16'sd0, 12'd0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      repeat (8) @(negedge clk);
      choose_axes();
      apply_axes();
      rx_mode = phase % 3;
      gaps_on = (phase != 1);
      n = 0;
      while (n < PHASE_ITEMS) begin
        burst_left = $urandom_range(1, 24);
        while (burst_left > 0 && n < PHASE_ITEMS) begin
          random_item();
          n++;
          burst_left--;
        end
        if (gaps_on) begin
          if ($urandom_range(0, 99) == 0) begin
            wait_drained();
          end else begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
              in_ch.valid <= 1'b0;
              repeat (gap) @(negedge clk);
            end
          end
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
